// File: rtl/core/project_4d_to_3d_defines.svh
// Assertion macros shared by the projection pipeline modules.
`ifndef PROJECT_4D_TO_3D_DEFINES_SVH
`define PROJECT_4D_TO_3D_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PRJ43_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("projection pipeline check failed");

// Next-cycle implication, disabled during reset.
`define PRJ43_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("projection pipeline check failed");

`endif

// File: rtl/core/prj43_pkg.sv
// Types and constants of the 4D-to-3D projection pipeline.
`default_nettype none

package prj43_pkg;

  localparam int VAL_W       = 16;
  localparam int LANES       = 4;
  localparam int AXES        = 3;
  localparam int DIFF_W      = 17;
  localparam int PROD_W      = 33;
  localparam int DOT_W       = 35;
  localparam int MUL_W       = 52;
  localparam int MAG_W       = 33;
  localparam int DEN_W       = 34;
  localparam int QUO_W       = 17;
  localparam int REM_W       = 51;
  localparam int CFG_W       = 64;
  localparam int IDX_W       = 3;
  localparam int SCALE_W     = 16;
  localparam int DEPTH_SHIFT = 14;
  localparam int PAR_SHIFT   = 22;

  localparam logic [VAL_W-1:0] VAL_MAX = 16'h7fff;
  localparam logic [VAL_W-1:0] VAL_MIN = 16'h8000;

  typedef enum logic [IDX_W-1:0] {
    REG_EYE,
    REG_BASIS_X,
    REG_BASIS_Y,
    REG_BASIS_Z,
    REG_BASIS_SIGHT,
    REG_PERSP,
    REG_SCALE
  } reg_idx_t;

  typedef struct packed {
    logic [LANES-1:0][VAL_W-1:0] pos;
    logic                        last;
  } vtx_t;

  typedef struct packed {
    logic [LANES-1:0][DOT_W-1:0] dot;
    logic                        last;
  } dot_t;

  typedef struct packed {
    logic [AXES-1:0][VAL_W-1:0] par;
    logic                       par_sat;
    logic [VAL_W-1:0]           depth;
    logic                       depth_sat;
    logic                       persp;
    logic                       zero;
    logic                       last;
  } side_t;

  typedef struct packed {
    logic [AXES-1:0][REM_W-1:0] num;
    logic [AXES-1:0]            neg;
    logic [DEN_W-1:0]           den;
    side_t                      side;
  } div_in_t;

  typedef struct packed {
    logic [AXES-1:0][QUO_W-1:0] q;
    logic [AXES-1:0]            ovf;
    logic [AXES-1:0]            neg;
    side_t                      side;
  } div_out_t;

  typedef struct packed {
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
    logic [VAL_W-1:0] depth;
    logic             sat;
    logic             zero;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/prj43_vtx_if.sv
// Vertex input channel: valid, ready and one 4D vertex.
`default_nettype none

interface prj43_vtx_if;
  logic        valid;
  logic        ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  logic [15:0] pos_w;
  logic        last_vertex;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output pos_w,
                  output last_vertex, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, input pos_w,
                input last_vertex, output ready);
endinterface

`default_nettype wire

// File: rtl/core/prj43_res_if.sv
// Result output channel: valid, ready and one projected vertex.
`default_nettype none

interface prj43_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] proj_x;
  logic [15:0] proj_y;
  logic [15:0] proj_z;
  logic [15:0] eye_depth;
  logic        saturated;
  logic        zero_depth;
  logic        last_out;

  modport source (output valid, output proj_x, output proj_y, output proj_z,
                  output eye_depth, output saturated, output zero_depth, output last_out,
                  input ready);
  modport sink (input valid, input proj_x, input proj_y, input proj_z,
                input eye_depth, input saturated, input zero_depth, input last_out,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/prj43_dot.sv
// Eye offset and four dot products with the basis vectors, three stages.
`default_nettype none

module prj43_dot (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic [prj43_pkg::CFG_W-1:0]                      eye,
  input  logic [prj43_pkg::LANES-1:0][prj43_pkg::CFG_W-1:0] basis,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  prj43_pkg::vtx_t                                  in_data,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output prj43_pkg::dot_t                                  out_data
);

  localparam int NSTG = 3;
  localparam int VW   = prj43_pkg::VAL_W;

  logic [NSTG-1:0] v;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] vin;

  logic [prj43_pkg::LANES-1:0][prj43_pkg::DIFF_W-1:0] diff, diff_next;
  logic [prj43_pkg::LANES-1:0][prj43_pkg::LANES-1:0][prj43_pkg::PROD_W-1:0] prod, prod_next;
  logic [prj43_pkg::LANES-1:0][prj43_pkg::DOT_W-1:0] dot, dot_next;
  logic [NSTG-1:0] last;

  assign vin = {v[NSTG-2:0], in_valid};

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int s = NSTG - 1; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  always_comb begin
    for (int k = 0; k < prj43_pkg::LANES; k++) begin
      diff_next[k] = {in_data.pos[k][VW-1], in_data.pos[k]}
                   - {eye[VW*k + VW - 1], eye[VW*k +: VW]};
    end
  end

  always_comb begin
    for (int j = 0; j < prj43_pkg::LANES; j++) begin
      for (int k = 0; k < prj43_pkg::LANES; k++) begin
        prod_next[j][k] = $signed(diff[k]) * $signed(basis[j][VW*k +: VW]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < prj43_pkg::LANES; j++) begin
      dot_next[j] = $signed(prod[j][0]) + $signed(prod[j][1])
                  + $signed(prod[j][2]) + $signed(prod[j][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (rdy[s]) begin
          v[s] <= vin[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && vin[0]) begin
      diff    <= diff_next;
      last[0] <= in_data.last;
    end
    if (rdy[1] && vin[1]) begin
      prod    <= prod_next;
      last[1] <= last[0];
    end
    if (rdy[2] && vin[2]) begin
      dot     <= dot_next;
      last[2] <= last[1];
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = v[NSTG-1];
  assign out_data.dot  = dot;
  assign out_data.last = last[NSTG-1];

endmodule

`default_nettype wire

// File: rtl/core/prj43_scale.sv
// Scale multiply, depth and parallel rounding, divider operand setup.
`default_nettype none

module prj43_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          persp,
  input  logic [prj43_pkg::SCALE_W-1:0] scale,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  prj43_pkg::dot_t               in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output prj43_pkg::div_in_t            out_data
);

  localparam int NSTG       = 2;
  localparam int MW         = prj43_pkg::MUL_W;
  localparam int DW         = prj43_pkg::DOT_W;
  localparam int NW         = prj43_pkg::MUL_W + 1;
  localparam int DEPTH_HALF = 1 << (prj43_pkg::DEPTH_SHIFT - 1);
  localparam int PAR_HALF   = 1 << (prj43_pkg::PAR_SHIFT - 1);
  localparam logic signed [MW-1:0] LIM_HI = MW'(32767);
  localparam logic signed [MW-1:0] LIM_LO = -MW'(32768);

  function automatic logic [prj43_pkg::VAL_W:0] sat16(input logic signed [MW-1:0] val);
    logic [prj43_pkg::VAL_W:0] r;
    if (val > LIM_HI) begin
      r = {1'b1, prj43_pkg::VAL_MAX};
    end else if (val < LIM_LO) begin
      r = {1'b1, prj43_pkg::VAL_MIN};
    end else begin
      r = {1'b0, val[prj43_pkg::VAL_W-1:0]};
    end
    return r;
  endfunction

  logic [NSTG-1:0] v;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] vin;

  logic [prj43_pkg::AXES-1:0][MW-1:0]     m, m_next;
  logic [prj43_pkg::MAG_W-1:0]            ad, ad_next;
  logic                                   dd_neg;
  logic [prj43_pkg::VAL_W-1:0]            depth;
  logic                                   depth_sat;
  logic                                   last_d;
  logic signed [DW-1:0]                   dd_s, dd_abs, dd_bias, depth_full;
  logic [prj43_pkg::VAL_W:0]              depth_r;

  logic [prj43_pkg::AXES-1:0][NW-1:0]     num_s;
  logic [prj43_pkg::AXES-1:0][MW-1:0]     par_full;
  logic [prj43_pkg::AXES-1:0][prj43_pkg::VAL_W:0] par_r;
  prj43_pkg::div_in_t                     e_next, e_data;

  assign vin = {v[NSTG-2:0], in_valid};

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int s = NSTG - 1; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  always_comb begin
    for (int j = 0; j < prj43_pkg::AXES; j++) begin
      m_next[j] = $signed(in_data.dot[j]) * $signed({1'b0, scale});
    end
    dd_s       = in_data.dot[prj43_pkg::LANES-1];
    dd_abs     = dd_s[DW-1] ? -dd_s : dd_s;
    ad_next    = dd_abs[prj43_pkg::MAG_W-1:0];
    dd_bias    = dd_s + (DW'(DEPTH_HALF) - DW'(dd_s[DW-1]));
    depth_full = dd_bias >>> prj43_pkg::DEPTH_SHIFT;
    depth_r    = sat16(MW'(depth_full));
  end

  always_comb begin
    e_next = '0;
    for (int j = 0; j < prj43_pkg::AXES; j++) begin
      if (m[j][MW-1]) begin
        num_s[j] = $signed(NW'(ad)) - $signed({m[j], 1'b0});
      end else begin
        num_s[j] = $signed(NW'(ad)) + $signed({m[j], 1'b0});
      end
      e_next.num[j] = num_s[j][prj43_pkg::REM_W-1:0];
      e_next.neg[j] = m[j][MW-1] ^ dd_neg;
      par_full[j]   = ($signed(m[j]) + $signed(MW'(PAR_HALF) - MW'(m[j][MW-1])))
                    >>> prj43_pkg::PAR_SHIFT;
      par_r[j]      = sat16(par_full[j]);
      e_next.side.par[j] = par_r[j][prj43_pkg::VAL_W-1:0];
    end
    e_next.den            = {ad, 1'b0};
    e_next.side.par_sat   = par_r[0][prj43_pkg::VAL_W] | par_r[1][prj43_pkg::VAL_W]
                          | par_r[2][prj43_pkg::VAL_W];
    e_next.side.depth     = depth;
    e_next.side.depth_sat = depth_sat;
    e_next.side.persp     = persp;
    e_next.side.zero      = persp && (ad == '0);
    e_next.side.last      = last_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (rdy[s]) begin
          v[s] <= vin[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && vin[0]) begin
      m         <= m_next;
      ad        <= ad_next;
      dd_neg    <= dd_s[DW-1];
      depth     <= depth_r[prj43_pkg::VAL_W-1:0];
      depth_sat <= depth_r[prj43_pkg::VAL_W];
      last_d    <= in_data.last;
    end
    if (rdy[1] && vin[1]) begin
      e_data <= e_next;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[NSTG-1];
  assign out_data  = e_data;

endmodule

`default_nettype wire

// File: rtl/core/prj43_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes.
`default_nettype none
`include "project_4d_to_3d_defines.svh"

module prj43_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  prj43_pkg::div_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prj43_pkg::div_out_t out_data
);

  localparam int NSTG = prj43_pkg::QUO_W + 1;
  localparam int LAST = NSTG - 1;
  localparam int RW   = prj43_pkg::REM_W;

  typedef struct packed {
    logic [prj43_pkg::AXES-1:0][RW-1:0]               rem;
    logic [prj43_pkg::AXES-1:0][prj43_pkg::QUO_W-1:0] q;
    logic [prj43_pkg::AXES-1:0]                       ovf;
    logic [prj43_pkg::AXES-1:0]                       neg;
    logic [prj43_pkg::DEN_W-1:0]                      den;
    prj43_pkg::side_t                                 side;
  } work_t;

  logic [NSTG-1:0] v;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] vin;
  work_t           st      [NSTG];
  work_t           st_next [NSTG];

  assign vin = {v[NSTG-2:0], in_valid};

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int s = NSTG - 1; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end

  always_comb begin
    logic [RW-1:0] trial;
    st_next[0].rem  = in_data.num;
    st_next[0].q    = '0;
    st_next[0].neg  = in_data.neg;
    st_next[0].den  = in_data.den;
    st_next[0].side = in_data.side;
    trial = RW'(in_data.den) << prj43_pkg::QUO_W;
    for (int j = 0; j < prj43_pkg::AXES; j++) begin
      st_next[0].ovf[j] = (in_data.num[j] >= trial);
    end
    for (int s = 1; s < NSTG; s++) begin
      st_next[s] = st[s-1];
      trial = RW'(st[s-1].den) << (prj43_pkg::QUO_W - s);
      for (int j = 0; j < prj43_pkg::AXES; j++) begin
        if (st[s-1].rem[j] >= trial) begin
          st_next[s].rem[j]                      = st[s-1].rem[j] - trial;
          st_next[s].q[j][prj43_pkg::QUO_W - s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (rdy[s]) begin
          v[s] <= vin[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (rdy[s] && vin[s]) begin
        st[s] <= st_next[s];
      end
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = v[LAST];
  assign out_data.q    = st[LAST].q;
  assign out_data.ovf  = st[LAST].ovf;
  assign out_data.neg  = st[LAST].neg;
  assign out_data.side = st[LAST].side;

  `PRJ43_ASSERT_NXT(a_div_hold, clk, rst, v[0] && !rdy[1], v[0] && $stable(st[0]))
  `PRJ43_ASSERT_IMP(a_rem_x, clk, rst, v[LAST] && !st[LAST].ovf[0], st[LAST].rem[0] < st[LAST].den)
  `PRJ43_ASSERT_IMP(a_rem_y, clk, rst, v[LAST] && !st[LAST].ovf[1], st[LAST].rem[1] < st[LAST].den)
  `PRJ43_ASSERT_IMP(a_rem_z, clk, rst, v[LAST] && !st[LAST].ovf[2], st[LAST].rem[2] < st[LAST].den)

endmodule

`default_nettype wire

// File: rtl/core/prj43_out.sv
// Quotient saturation, mode select and the result register.
`default_nettype none
`include "project_4d_to_3d_defines.svh"

module prj43_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  prj43_pkg::div_out_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prj43_pkg::res_t     out_data
);

  localparam int QW = prj43_pkg::QUO_W;
  localparam logic [QW-1:0] NEG_LIM = QW'(1 << (prj43_pkg::VAL_W - 1));
  localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

  logic                                              v;
  logic                                              rdy;
  logic [prj43_pkg::AXES-1:0][prj43_pkg::VAL_W-1:0] lane_val;
  logic [prj43_pkg::AXES-1:0]                        lane_sat;
  logic [QW-1:0]                                     q_neg;
  prj43_pkg::res_t                                   res_next, res;

  assign rdy = !v || out_ready;

  always_comb begin
    for (int j = 0; j < prj43_pkg::AXES; j++) begin
      q_neg = -in_data.q[j];
      if (!in_data.side.persp) begin
        lane_val[j] = in_data.side.par[j];
        lane_sat[j] = in_data.side.par_sat;
      end else if (in_data.side.zero) begin
        lane_val[j] = '0;
        lane_sat[j] = 1'b0;
      end else if (in_data.neg[j]) begin
        if (in_data.ovf[j] || (in_data.q[j] > NEG_LIM)) begin
          lane_val[j] = prj43_pkg::VAL_MIN;
          lane_sat[j] = 1'b1;
        end else begin
          lane_val[j] = q_neg[prj43_pkg::VAL_W-1:0];
          lane_sat[j] = 1'b0;
        end
      end else begin
        if (in_data.ovf[j] || (in_data.q[j] > POS_LIM)) begin
          lane_val[j] = prj43_pkg::VAL_MAX;
          lane_sat[j] = 1'b1;
        end else begin
          lane_val[j] = in_data.q[j][prj43_pkg::VAL_W-1:0];
          lane_sat[j] = 1'b0;
        end
      end
    end
    res_next.x     = lane_val[0];
    res_next.y     = lane_val[1];
    res_next.z     = lane_val[2];
    res_next.depth = in_data.side.depth;
    res_next.sat   = (|lane_sat) | in_data.side.depth_sat;
    res_next.zero  = in_data.side.zero;
    res_next.last  = in_data.side.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (rdy) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      res <= res_next;
    end
  end

  assign in_ready  = rdy;
  assign out_valid = v;
  assign out_data  = res;

  `PRJ43_ASSERT_IMP(a_zero_clears, clk, rst, v && res.zero, (res.x == '0) && (res.y == '0) && (res.z == '0) && !res.sat)

endmodule

`default_nettype wire

// File: rtl/core/project_4d_to_3d.sv
// Top level of the 4D-to-3D projection pipeline with its register file.
`default_nettype none

// Projects each signed Q8.8 4D vertex onto a 3D view: the eye point is
// subtracted, four dot products with the Q1.14 basis give x, y, z and the depth
// along the line of sight, and x, y, z are scaled (parallel mode) or scaled and
// divided by the depth (perspective mode), each rounded and saturated to Q8.8.
// A vertex can be transferred every cycle unless stalled; the path from input
// to result has three stages for the offset, products and dot sums, two for
// the scale multiply and divider setup, eighteen for the restoring divider (an
// overflow check and then one quotient bit per stage), and the result register.
// Stalls on the result side fill any empty stages before the input side stalls.
// Registers are written through cfg_we, cfg_index and cfg_data, and take effect
// for every vertex; write them only while no vertex is in flight.
module project_4d_to_3d (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [prj43_pkg::IDX_W-1:0]   cfg_index,
  input  logic [prj43_pkg::CFG_W-1:0]   cfg_data,
  prj43_vtx_if.sink                     vtx,
  prj43_res_if.source                   res
);

  localparam logic [prj43_pkg::SCALE_W-1:0] SCALE_RESET = 16'd256;
  localparam logic                          PERSP_RESET = 1'b1;

  logic [prj43_pkg::CFG_W-1:0]                       eye;
  logic [prj43_pkg::LANES-1:0][prj43_pkg::CFG_W-1:0] basis;
  logic                                              persp;
  logic [prj43_pkg::SCALE_W-1:0]                     scale;

  prj43_pkg::vtx_t     vtx_data;
  prj43_pkg::dot_t     dot_data;
  prj43_pkg::div_in_t  div_in;
  prj43_pkg::div_out_t div_out;
  prj43_pkg::res_t     res_data;

  logic dot_valid, dot_ready;
  logic scl_valid, scl_ready;
  logic div_valid, div_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye   <= '0;
      basis <= '0;
      persp <= PERSP_RESET;
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (prj43_pkg::reg_idx_t'(cfg_index))
        prj43_pkg::REG_EYE:         eye      <= cfg_data;
        prj43_pkg::REG_BASIS_X:     basis[0] <= cfg_data;
        prj43_pkg::REG_BASIS_Y:     basis[1] <= cfg_data;
        prj43_pkg::REG_BASIS_Z:     basis[2] <= cfg_data;
        prj43_pkg::REG_BASIS_SIGHT: basis[3] <= cfg_data;
        prj43_pkg::REG_PERSP:       persp    <= cfg_data[0];
        prj43_pkg::REG_SCALE:       scale    <= cfg_data[prj43_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign vtx_data.pos[0] = vtx.pos_x;
  assign vtx_data.pos[1] = vtx.pos_y;
  assign vtx_data.pos[2] = vtx.pos_z;
  assign vtx_data.pos[3] = vtx.pos_w;
  assign vtx_data.last   = vtx.last_vertex;

  prj43_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .eye       (eye),
    .basis     (basis),
    .in_valid  (vtx.valid),
    .in_ready  (vtx.ready),
    .in_data   (vtx_data),
    .out_valid (dot_valid),
    .out_ready (dot_ready),
    .out_data  (dot_data)
  );

  prj43_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .persp     (persp),
    .scale     (scale),
    .in_valid  (dot_valid),
    .in_ready  (dot_ready),
    .in_data   (dot_data),
    .out_valid (scl_valid),
    .out_ready (scl_ready),
    .out_data  (div_in)
  );

  prj43_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scl_valid),
    .in_ready  (scl_ready),
    .in_data   (div_in),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_out)
  );

  prj43_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_out),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res_data)
  );

  assign res.proj_x     = res_data.x;
  assign res.proj_y     = res_data.y;
  assign res.proj_z     = res_data.z;
  assign res.eye_depth  = res_data.depth;
  assign res.saturated  = res_data.sat;
  assign res.zero_depth = res_data.zero;
  assign res.last_out   = res_data.last;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the 4D-to-3D projection pipeline.
module testbench;

  localparam logic [prj43_pkg::IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int PIPE_CYCLES  = 24;
  localparam int SETTLE_WAIT  = PIPE_CYCLES + 16;
  localparam int HOLD_CYCLES  = 90;
  localparam int QUIET_LIMIT  = 3000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 75;

  typedef enum logic [1:0] {ROW_WRITE, ROW_VERTEX, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [prj43_pkg::IDX_W-1:0]     index;
    logic [prj43_pkg::CFG_W-1:0]     data;
    prj43_pkg::vtx_t                 v;
    prj43_pkg::res_t                 want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [prj43_pkg::IDX_W-1:0] cfg_index;
  logic [prj43_pkg::CFG_W-1:0] cfg_data;

  prj43_vtx_if vtx ();
  prj43_res_if res ();

  project_4d_to_3d uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx       (vtx),
    .res       (res)
  );

  logic [prj43_pkg::CFG_W-1:0]   cur_eye;
  logic [prj43_pkg::CFG_W-1:0]   cur_basis [4];
  logic                          cur_persp;
  logic [prj43_pkg::SCALE_W-1:0] cur_scale;

  prj43_pkg::res_t pending_proj[$];
  row_t plan[$];
  int   sent_vertices;
  int   checked_results;
  int   zero_seen;
  int   sat_seen;
  int   mismatches;
  int   settings_used;
  int   quiet_cycles;
  bit   calm;
  bit   hold_req;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic longint round_div(longint num, longint den);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic prj43_pkg::res_t project_vertex(prj43_pkg::vtx_t v);
    longint diff [4];
    longint dot [4];
    longint vals [4];
    prj43_pkg::res_t r;
    logic   sat;
    logic   zero;
    sat = 1'b0;
    zero = 1'b0;
    for (int k = 0; k < prj43_pkg::LANES; k++)
      diff[k] = longint'($signed(v.pos[k])) - longint'($signed(cur_eye[16*k +: 16]));
    for (int a = 0; a < 4; a++) begin
      dot[a] = 0;
      for (int k = 0; k < prj43_pkg::LANES; k++)
        dot[a] += diff[k] * longint'($signed(cur_basis[a][16*k +: 16]));
    end
    vals[3] = round_div(dot[3], longint'(1) << prj43_pkg::DEPTH_SHIFT);
    for (int a = 0; a < prj43_pkg::AXES; a++) begin
      if (!cur_persp) begin
        vals[a] = round_div(dot[a] * longint'(cur_scale),
                            longint'(1) << prj43_pkg::PAR_SHIFT);
      end else if (dot[3] == 0) begin
        zero = 1'b1;
        vals[a] = 0;
      end else begin
        vals[a] = round_div(dot[a] * longint'(cur_scale), dot[3]);
      end
    end
    for (int a = 0; a < 4; a++) begin
      if (vals[a] > 32767) begin
        sat = 1'b1;
        vals[a] = 32767;
      end else if (vals[a] < -32768) begin
        sat = 1'b1;
        vals[a] = -32768;
      end
    end
    r.x     = vals[0][15:0];
    r.y     = vals[1][15:0];
    r.z     = vals[2][15:0];
    r.depth = vals[3][15:0];
    r.sat   = sat;
    r.zero  = zero;
    r.last  = v.last;
    return r;
  endfunction

  function automatic prj43_pkg::vtx_t make_vertex(logic [15:0] x, logic [15:0] y,
                                                  logic [15:0] z, logic [15:0] w,
                                                  logic last);
    prj43_pkg::vtx_t v;
    v.pos[0] = x;
    v.pos[1] = y;
    v.pos[2] = z;
    v.pos[3] = w;
    v.last   = last;
    return v;
  endfunction

  function automatic prj43_pkg::res_t make_result(logic [15:0] x, logic [15:0] y,
                                                  logic [15:0] z, logic [15:0] d,
                                                  logic sat, logic zero, logic last);
    prj43_pkg::res_t r;
    r.x     = x;
    r.y     = y;
    r.z     = z;
    r.depth = d;
    r.sat   = sat;
    r.zero  = zero;
    r.last  = last;
    return r;
  endfunction

  function automatic row_t wr(logic [prj43_pkg::IDX_W-1:0] index,
                              logic [prj43_pkg::CFG_W-1:0] data);
    row_t row;
    row = '0;
    row.kind  = ROW_WRITE;
    row.index = index;
    row.data  = data;
    return row;
  endfunction

  function automatic row_t vx(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [15:0] w, logic last);
    row_t row;
    row = '0;
    row.kind = ROW_VERTEX;
    row.v    = make_vertex(x, y, z, w, last);
    return row;
  endfunction

  function automatic row_t vt(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [15:0] w, logic last, prj43_pkg::res_t want);
    row_t row;
    row = vx(x, y, z, w, last);
    row.kind = ROW_TYPED;
    row.want = want;
    return row;
  endfunction

  function automatic logic [prj43_pkg::CFG_W-1:0] pick_basis(int kind);
    logic [prj43_pkg::CFG_W-1:0] b;
    for (int k = 0; k < prj43_pkg::LANES; k++) begin
      case (kind)
        0:       b[16*k +: 16] = 16'($urandom_range(32768)) - 16'd16384;
        1:       b[16*k +: 16] = 16'($urandom);
        default: b[16*k +: 16] = $urandom_range(1) ? prj43_pkg::VAL_MAX : prj43_pkg::VAL_MIN;
      endcase
    end
    return b;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic write_reg(logic [prj43_pkg::IDX_W-1:0] index,
                           logic [prj43_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    case (index)
      prj43_pkg::REG_EYE:         cur_eye = data;
      prj43_pkg::REG_BASIS_X:     cur_basis[0] = data;
      prj43_pkg::REG_BASIS_Y:     cur_basis[1] = data;
      prj43_pkg::REG_BASIS_Z:     cur_basis[2] = data;
      prj43_pkg::REG_BASIS_SIGHT: cur_basis[3] = data;
      prj43_pkg::REG_PERSP:       cur_persp = data[0];
      prj43_pkg::REG_SCALE:       cur_scale = data[prj43_pkg::SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    vtx.valid = 1'b0;
    while (pending_proj.size() != 0) @(negedge clk);
  endtask

  task automatic send_vertex(prj43_pkg::vtx_t v, bit typed, prj43_pkg::res_t want);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 16) begin
      vtx.valid = 1'b0;
      @(negedge clk);
    end
    vtx.valid       = 1'b1;
    vtx.pos_x       = v.pos[0];
    vtx.pos_y       = v.pos[1];
    vtx.pos_z       = v.pos[2];
    vtx.pos_w       = v.pos[3];
    vtx.last_vertex = v.last;
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
    pending_proj.push_back(typed ? want : project_vertex(v));
    sent_vertices++;
  endtask

  always @(posedge clk) begin : result_check
    prj43_pkg::res_t want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((vtx.valid && vtx.ready) || (res.valid && res.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (res.valid && res.ready) begin
        if (pending_proj.size() == 0) begin
          $error("result transfer with no vertex pending");
          mismatches++;
        end else begin
          want = pending_proj.pop_front();
          check_field("proj_x", want.x, res.proj_x);
          check_field("proj_y", want.y, res.proj_y);
          check_field("proj_z", want.z, res.proj_z);
          check_field("eye_depth", want.depth, res.eye_depth);
          check_field("saturated", 16'(want.sat), 16'(res.saturated));
          check_field("zero_depth", 16'(want.zero), 16'(res.zero_depth));
          check_field("last_out", 16'(want.last), 16'(res.last_out));
          checked_results++;
          if (want.zero) zero_seen++;
          if (want.sat) sat_seen++;
        end
      end
    end
  end

  initial begin : result_side
    bit held;
    held = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        res.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res.ready = calm || ($urandom_range(99) >= 16);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    prj43_pkg::reg_idx_t basis_regs [4];
    int                  basis_kind [PHASES];
    prj43_pkg::vtx_t     v;
    row_t                row;
    int                  pick;
    logic [prj43_pkg::CFG_W-1:0] data;
    basis_regs = '{prj43_pkg::REG_BASIS_X, prj43_pkg::REG_BASIS_Y,
                   prj43_pkg::REG_BASIS_Z, prj43_pkg::REG_BASIS_SIGHT};
    basis_kind = '{0, 0, 1, 2, 2, 1};
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = prj43_pkg::REG_EYE;
    cfg_data        = '0;
    vtx.valid       = 1'b0;
    vtx.pos_x       = '0;
    vtx.pos_y       = '0;
    vtx.pos_z       = '0;
    vtx.pos_w       = '0;
    vtx.last_vertex = 1'b0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    sent_vertices   = 0;
    checked_results = 0;
    zero_seen       = 0;
    sat_seen        = 0;
    mismatches      = 0;
    settings_used   = 1;
    cur_eye         = '0;
    for (int a = 0; a < 4; a++) cur_basis[a] = '0;
    cur_persp       = 1'b1;
    cur_scale       = 16'd256;

    // reset state: zero basis in perspective gives zero depth
    plan.push_back(vt(16'h0100, 16'h0200, 16'h0300, 16'h0400, 1'b0,
                      make_result(16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1, 1'b0)));
    plan.push_back(vt(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1,
                      make_result(16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1, 1'b1)));
    plan.push_back(wr(prj43_pkg::REG_BASIS_X, 64'h0000_0000_0000_4000));
    plan.push_back(wr(prj43_pkg::REG_BASIS_Y, 64'h0000_0000_4000_0000));
    plan.push_back(wr(prj43_pkg::REG_BASIS_Z, 64'h0000_4000_0000_0000));
    plan.push_back(wr(prj43_pkg::REG_BASIS_SIGHT, 64'h4000_0000_0000_0000));
    plan.push_back(wr(prj43_pkg::REG_PERSP, 64'hffff_ffff_ffff_fffe));
    plan.push_back(vt(16'h1234, 16'hedcb, 16'h0001, 16'hffff, 1'b0,
                      make_result(16'h1234, 16'hedcb, 16'h0001, 16'hffff, 1'b0, 1'b0, 1'b0)));
    plan.push_back(vt(16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 1'b0,
                      make_result(16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 1'b0, 1'b0, 1'b0)));
    plan.push_back(wr(prj43_pkg::REG_EYE, 64'h7fff_7fff_7fff_7fff));
    plan.push_back(vt(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1,
                      make_result(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, 1'b1)));
    plan.push_back(vt(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0,
                      make_result(16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(vx(16'h8001, 16'hfffe, 16'h0000, 16'h7ffe, 1'b0));
    plan.push_back(wr(prj43_pkg::REG_SCALE, 64'hffff_0000_0000_0080));
    plan.push_back(vx(16'h0003, 16'hfffd, 16'h7fff, 16'h0001, 1'b0));
    plan.push_back(vx(16'h8000, 16'h7fff, 16'h1235, 16'h0000, 1'b0));
    plan.push_back(wr(prj43_pkg::REG_PERSP, 64'h1234_5678_9abc_def1));
    plan.push_back(wr(prj43_pkg::REG_EYE, 64'h0));
    plan.push_back(vt(16'h0100, 16'h0200, 16'hff00, 16'h0100, 1'b0,
                      make_result(16'h0080, 16'h0100, 16'hff80, 16'h0100, 1'b0, 1'b0, 1'b0)));
    plan.push_back(vt(16'h0100, 16'h0200, 16'h0300, 16'h0000, 1'b1,
                      make_result(16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1, 1'b1)));
    plan.push_back(vx(16'h7fff, 16'h8000, 16'h0001, 16'h0001, 1'b0));
    plan.push_back(vx(16'h0003, 16'h0001, 16'hfffd, 16'hfffa, 1'b0));
    plan.push_back(wr(prj43_pkg::REG_SCALE, 64'h0));
    plan.push_back(vx(16'h1234, 16'h8000, 16'h7fff, 16'h0040, 1'b0));
    plan.push_back(wr(prj43_pkg::REG_SCALE, 64'h0000_0000_0000_ffff));
    plan.push_back(vx(16'h0101, 16'hfeff, 16'h0000, 16'h7fff, 1'b0));
    plan.push_back(wr(REG_SPARE, 64'h0123_4567_89ab_cdef));
    plan.push_back(wr(prj43_pkg::REG_BASIS_X, 64'h8000_7fff_8000_7fff));
    plan.push_back(wr(prj43_pkg::REG_BASIS_Y, 64'h7fff_7fff_7fff_7fff));
    plan.push_back(wr(prj43_pkg::REG_BASIS_Z, 64'h8000_8000_8000_8000));
    plan.push_back(wr(prj43_pkg::REG_BASIS_SIGHT, 64'hc000_4000_c000_4000));
    plan.push_back(vx(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1));
    plan.push_back(vx(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    plan.push_back(vx(16'h0010, 16'h0010, 16'h0010, 16'h0010, 1'b0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      row = plan[i];
      case (row.kind)
        ROW_WRITE: begin
          drain();
          write_reg(row.index, row.data);
          settings_used++;
        end
        ROW_TYPED: send_vertex(row.v, 1'b1, row.want);
        default:   send_vertex(row.v, 1'b0, row.want);
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      calm = (ph == 1);
      write_reg(prj43_pkg::REG_EYE, (ph == 0) ? 64'h0 : {$urandom, $urandom});
      for (int a = 0; a < 4; a++) write_reg(basis_regs[a], pick_basis(basis_kind[ph]));
      write_reg(prj43_pkg::REG_PERSP,
                {$urandom, $urandom_range(1) ? 32'hffff_fffe : 32'h0} |
                prj43_pkg::CFG_W'(ph % 2 == 0));
      data = {$urandom, $urandom};
      if (ph == 2 || ph == 5)
        data[prj43_pkg::SCALE_W-1:0] = 16'hffff;
      else if (ph == 3 || ph == 4)
        data[prj43_pkg::SCALE_W-1:0] = 16'h0;
      write_reg(prj43_pkg::REG_SCALE, data);
      write_reg(REG_SPARE, {$urandom, $urandom});
      settings_used++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(15);
        for (int k = 0; k < prj43_pkg::LANES; k++) begin
          if (pick == 0)
            v.pos[k] = cur_eye[16*k +: 16];
          else if (pick <= 4)
            v.pos[k] = cur_eye[16*k +: 16] + 16'($urandom_range(1023)) - 16'd512;
          else
            v.pos[k] = 16'($urandom);
        end
        v.last = (i == PHASE_ITEMS - 1) || ($urandom_range(7) == 0);
        if (ph == 2 && i == 5) hold_req = 1'b1;
        send_vertex(v, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_WAIT) @(negedge clk);
    $display("Sent %0d vertices through %0d register settings, parallel and perspective",
             sent_vertices, settings_used);
    $display("Checked %0d results: %0d with zero depth, %0d saturated",
             checked_results, zero_seen, sat_seen);
    if (mismatches == 0 && pending_proj.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/prj43_pkg.sv
rtl/core/prj43_vtx_if.sv
rtl/core/prj43_res_if.sv
rtl/core/prj43_dot.sv
rtl/core/prj43_scale.sv
rtl/core/prj43_div.sv
rtl/core/prj43_out.sv
rtl/core/project_4d_to_3d.sv
sim/testbench.sv
